// ----- src/lcg_card_deal_generator_core_defines.svh -----
// ----------------------------------------------------------------------------
// Card deal generator assertion macros
// Shared assertion forms for the deal generator, clocked on clk and quiet
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LCG_CARD_DEAL_GENERATOR_CORE_DEFINES_SVH
`define LCG_CARD_DEAL_GENERATOR_CORE_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define LCGCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define LCGCD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/lcgcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card deal generator package
// Generator constants, field widths, state machine types and the queue
// status record shared by the deal generator modules.
// ----------------------------------------------------------------------------
package lcgcd_pkg;

  localparam logic [31:0] LCG_MUL = 32'd214013;
  localparam logic [31:0] LCG_ADD = 32'd2531011;

  // The draw is bits 30..16 of the generator state.
  localparam int DRAW_MSB = 30;
  localparam int DRAW_LSB = 16;
  localparam int VALUE_W  = DRAW_MSB - DRAW_LSB + 1;

  // Remainder unit: restoring steps, three bits per cycle.
  localparam int MOD_BITS_PER_CYCLE = 3;
  localparam int MOD_CYCLES         = VALUE_W / MOD_BITS_PER_CYCLE;
  localparam int MOD_CNT_W          = $clog2(MOD_CYCLES);

  localparam int CARD_W   = 6;
  localparam int COLUMN_W = 3;
  localparam int ROW_W    = 3;

  localparam int PICK_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_STEP,
    FR_MOD,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FILL,
    BK_WAIT,
    BK_SWAP
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ----- src/lcg_card_deal_generator_core.sv -----
// ----------------------------------------------------------------------------
// Card deal generator core
// A deal's pace is set by the draw engine: a generator step, the remainder
// steps and a push per card, with stalls on the full pick queue while the
// deck engine fills the deck. The first card follows the fill; busy drops
// after the last card. Synchronous active-low reset returns both engines
// and the queue to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lcg_card_deal_generator_core_defines.svh"

module lcg_card_deal_generator_core #(
  parameter int DECK_CARDS = 52,
  parameter int LAYOUT_COLUMNS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [31:0]                    in_game_number,
  output logic                           busy,
  output logic                           out_valid,
  output logic [lcgcd_pkg::CARD_W-1:0]   out_card,
  output logic [lcgcd_pkg::COLUMN_W-1:0] out_column,
  output logic [lcgcd_pkg::ROW_W-1:0]    out_row,
  output logic                           out_last
);
  import lcgcd_pkg::*;

  localparam int IW = $clog2(DECK_CARDS);

  logic          deal_start;
  logic          front_busy;
  logic          back_busy;
  logic          pick_push;
  logic          pick_pop;
  logic [IW-1:0] pick_in;
  logic [IW-1:0] pick_out;
  queue_stat_t   pick_stat;

  assign deal_start = start && !busy;
  assign busy       = front_busy || back_busy;

  lcgcd_front #(
    .DECK_CARDS (DECK_CARDS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .deal_start  (deal_start),
    .game_number (in_game_number),
    .queue_stat  (pick_stat),
    .pick_push   (pick_push),
    .pick_data   (pick_in),
    .busy        (front_busy)
  );

  lcgcd_pick_fifo #(
    .WIDTH (IW),
    .DEPTH (PICK_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pick_push),
    .push_data (pick_in),
    .pop       (pick_pop),
    .pop_data  (pick_out),
    .stat      (pick_stat)
  );

  lcgcd_back #(
    .DECK_CARDS     (DECK_CARDS),
    .LAYOUT_COLUMNS (LAYOUT_COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .deal_start (deal_start),
    .pick       (pick_out),
    .queue_stat (pick_stat),
    .pick_pop   (pick_pop),
    .out_valid  (out_valid),
    .out_card   (out_card),
    .out_column (out_column),
    .out_row    (out_row),
    .out_last   (out_last),
    .busy       (back_busy)
  );

  // Cards only come out while a deal is in progress.
  `LCGCD_ASSERT(a_card_in_deal, out_valid |-> busy, "card strobe outside a deal")
  // An accepted transaction keeps the core busy on the next cycle.
  `LCGCD_ASSERT(a_start_busy, deal_start |=> busy, "core idle right after start")
  // The draw engine must never push into a full pick queue.
  `LCGCD_NEVER(a_queue_overflow, pick_push && pick_stat.full, "pick queue overflow")
  // The last card ends the deal: no card follows it directly.
  `LCGCD_ASSERT(a_last_ends, out_valid && out_last |=> !out_valid && !busy,
                "activity after the last card")

endmodule

// ----- src/lcgcd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, each read registered.
// ----------------------------------------------------------------------------
module lcgcd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 52,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- src/lcgcd_pick_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pick queue
// Short register queue of slot picks between the draw engine and the deck
// engine.
// ----------------------------------------------------------------------------
module lcgcd_pick_fifo #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 4,
  localparam int QW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output lcgcd_pkg::queue_stat_t     stat
);
  import lcgcd_pkg::*;

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [QW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_comb begin
    stat.full  = (count_r == (QW+1)'(DEPTH));
    stat.empty = (count_r == '0);
    pop_data   = slot_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QW'(DEPTH - 1)) ? '0 : wr_ptr_r + QW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QW'(DEPTH - 1)) ? '0 : rd_ptr_r + QW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/lcgcd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Draw engine
// Seeds the generator from the deal number, steps it once per card and
// reduces each draw modulo the count of cards left, queuing the slot picks.
// ----------------------------------------------------------------------------
module lcgcd_front #(
  parameter int DECK_CARDS = 52,
  localparam int IW = $clog2(DECK_CARDS),
  localparam int CW = $clog2(DECK_CARDS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   deal_start,
  input  logic [31:0]            game_number,
  input  lcgcd_pkg::queue_stat_t queue_stat,
  output logic                   pick_push,
  output logic [IW-1:0]          pick_data,
  output logic                   busy
);
  import lcgcd_pkg::*;

  localparam int DW = VALUE_W + CW;

  front_state_t         state_r, state_nxt;
  logic [31:0]          lcg_r, lcg_nxt;
  logic [CW-1:0]        left_r, left_nxt;
  logic [VALUE_W-1:0]   rem_r, rem_nxt;
  logic [MOD_CNT_W-1:0] mod_cnt_r, mod_cnt_nxt;
  logic [VALUE_W-1:0]   rem_step;
  logic [DW-1:0]        divisor_sh;
  logic [4:0]           sh;

  // Three restoring remainder steps on the current window of shifts.
  always_comb begin
    rem_step   = rem_r;
    divisor_sh = '0;
    sh         = '0;
    for (int j = 0; j < MOD_BITS_PER_CYCLE; j++) begin
      sh = 5'(VALUE_W - 1 - MOD_BITS_PER_CYCLE * int'(mod_cnt_r) - j);
      divisor_sh = DW'(left_r) << sh;
      if (DW'(rem_step) >= divisor_sh) begin
        rem_step = rem_step - VALUE_W'(divisor_sh);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    lcg_nxt     = lcg_r;
    left_nxt    = left_r;
    rem_nxt     = rem_r;
    mod_cnt_nxt = mod_cnt_r;
    pick_push   = 1'b0;
    pick_data   = IW'(rem_r);
    busy        = (state_r != FR_IDLE);
    unique case (state_r)
      FR_IDLE: begin
        if (deal_start) begin
          lcg_nxt   = game_number;
          left_nxt  = CW'(DECK_CARDS);
          state_nxt = FR_STEP;
        end
      end
      FR_STEP: begin
        lcg_nxt     = 32'(lcg_r * LCG_MUL) + LCG_ADD;
        rem_nxt     = lcg_nxt[DRAW_MSB:DRAW_LSB];
        mod_cnt_nxt = '0;
        state_nxt   = FR_MOD;
      end
      FR_MOD: begin
        rem_nxt = rem_step;
        if (mod_cnt_r == MOD_CNT_W'(MOD_CYCLES - 1)) begin
          state_nxt = FR_PUSH;
        end else begin
          mod_cnt_nxt = mod_cnt_r + MOD_CNT_W'(1);
        end
      end
      FR_PUSH: begin
        if (!queue_stat.full) begin
          pick_push = 1'b1;
          left_nxt  = left_r - CW'(1);
          state_nxt = (left_r == CW'(1)) ? FR_IDLE : FR_STEP;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      lcg_r   <= '0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lcg_r   <= lcg_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    mod_cnt_r <= mod_cnt_nxt;
  end

endmodule

// ----- src/lcgcd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deck engine
// Fills the deck in identity order, then for each queued pick reads the
// picked slot and the last live slot, emits the card and refills the slot.
// ----------------------------------------------------------------------------
module lcgcd_back #(
  parameter int DECK_CARDS = 52,
  parameter int LAYOUT_COLUMNS = 8,
  localparam int IW = $clog2(DECK_CARDS),
  localparam int CW = $clog2(DECK_CARDS + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             deal_start,
  input  logic [IW-1:0]                    pick,
  input  lcgcd_pkg::queue_stat_t           queue_stat,
  output logic                             pick_pop,
  output logic                             out_valid,
  output logic [lcgcd_pkg::CARD_W-1:0]     out_card,
  output logic [lcgcd_pkg::COLUMN_W-1:0]   out_column,
  output logic [lcgcd_pkg::ROW_W-1:0]      out_row,
  output logic                             out_last,
  output logic                             busy
);
  import lcgcd_pkg::*;

  localparam int COLW    = (LAYOUT_COLUMNS > 1) ? $clog2(LAYOUT_COLUMNS) : 1;
  localparam int ROWS    = (DECK_CARDS - 1) / LAYOUT_COLUMNS + 1;
  localparam int ROWW    = (ROWS > 1) ? $clog2(ROWS) : 1;

  back_state_t     state_r, state_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   left_r, left_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic [ROWW-1:0] row_r, row_nxt;
  logic [IW-1:0]   pick_r, pick_nxt;
  logic            last_pos;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [CARD_W-1:0] mem_wdata;
  logic [IW-1:0]     mem_raddr_a;
  logic [IW-1:0]     mem_raddr_b;
  logic [CARD_W-1:0] mem_rdata_a;
  logic [CARD_W-1:0] mem_rdata_b;

  lcgcd_ram #(
    .WIDTH (CARD_W),
    .DEPTH (DECK_CARDS)
  ) u_deck (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  assign last_pos = (pos_r == IW'(DECK_CARDS - 1));

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    left_nxt    = left_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    pick_nxt    = pick_r;
    pick_pop    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pos_r;
    mem_wdata   = CARD_W'(pos_r);
    mem_raddr_a = pick;
    mem_raddr_b = IW'(left_r - CW'(1));
    out_valid   = 1'b0;
    out_card    = mem_rdata_a;
    out_column  = COLUMN_W'(col_r);
    out_row     = ROW_W'(row_r);
    out_last    = 1'b0;
    busy        = (state_r != BK_IDLE);
    unique case (state_r)
      BK_IDLE: begin
        if (deal_start) begin
          pos_nxt   = '0;
          left_nxt  = CW'(DECK_CARDS);
          col_nxt   = '0;
          row_nxt   = '0;
          state_nxt = BK_FILL;
        end
      end
      BK_FILL: begin
        mem_we = 1'b1;
        if (last_pos) begin
          pos_nxt   = '0;
          state_nxt = BK_WAIT;
        end else begin
          pos_nxt = pos_r + IW'(1);
        end
      end
      BK_WAIT: begin
        // The picked-slot read address comes straight from the queue head.
        if (!queue_stat.empty) begin
          pick_pop  = 1'b1;
          pick_nxt  = pick;
          state_nxt = BK_SWAP;
        end
      end
      BK_SWAP: begin
        out_valid = 1'b1;
        out_last  = last_pos;
        mem_we    = 1'b1;
        mem_waddr = pick_r;
        mem_wdata = mem_rdata_b;
        left_nxt  = left_r - CW'(1);
        if (col_r == COLW'(LAYOUT_COLUMNS - 1)) begin
          col_nxt = '0;
          row_nxt = row_r + ROWW'(1);
        end else begin
          col_nxt = col_r + COLW'(1);
        end
        if (last_pos) begin
          state_nxt = BK_IDLE;
        end else begin
          pos_nxt   = pos_r + IW'(1);
          state_nxt = BK_WAIT;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      pos_r   <= '0;
      left_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      left_r  <= left_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pick_r <= pick_nxt;
  end

endmodule

// ----- test/lcg_card_deal_generator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card deal generator testbench
// Sends deal numbers through the start/busy handshake and checks every card
// the core emits against a deal computed in the bench itself: generator
// steps, remainder pick, deck refill, column, row and the final-card flag.
// Directed seeds come first, then random deals sent in bursts with gaps.
// ----------------------------------------------------------------------------
module lcg_card_deal_generator_core_tb;
  import lcgcd_pkg::*;

  localparam int DECK = 52;
  localparam int COLS = 8;
  localparam int RANDOM_DEALS = 114;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    logic [CARD_W-1:0]   card;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic                last;
  } dealt_card_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [31:0]         in_game_number = 32'd0;
  logic                busy;
  logic                out_valid;
  logic [CARD_W-1:0]   out_card;
  logic [COLUMN_W-1:0] out_column;
  logic [ROW_W-1:0]    out_row;
  logic                out_last;

  dealt_card_t cards_due[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;

  lcg_card_deal_generator_core #(
    .DECK_CARDS(DECK),
    .LAYOUT_COLUMNS(COLS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_game_number(in_game_number),
    .busy(busy),
    .out_valid(out_valid),
    .out_card(out_card),
    .out_column(out_column),
    .out_row(out_row),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Deals the whole layout for one seed and queues the cards in deal order.
  function automatic void deal_layout(input logic [31:0] seed);
    logic [31:0]       gen;
    logic [CARD_W-1:0] slots[DECK];
    logic [14:0]       draw;
    int unsigned       remaining;
    int unsigned       pick;
    dealt_card_t       c;
    gen = seed;
    for (int p = 0; p < DECK; p++) slots[p] = p[CARD_W-1:0];
    remaining = DECK;
    for (int p = 0; p < DECK; p++) begin
      gen = gen * LCG_MUL + LCG_ADD;
      draw = gen[DRAW_MSB:DRAW_LSB];
      pick = draw % remaining;
      c.card = slots[pick];
      c.column = COLUMN_W'((p % COLS) & 7);
      c.row = ROW_W'((p / COLS) & 7);
      c.last = (p == DECK - 1);
      cards_due.push_back(c);
      remaining--;
      slots[pick] = slots[remaining];
    end
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Accepted deals queue their cards; each strobed card is checked in order.
  always @(posedge clk) begin
    dealt_card_t want;
    if (rst_n) begin
      if (start && !busy) deal_layout(in_game_number);
      if (out_valid) begin
        if (cards_due.size() == 0) begin
          $error("card %0d with no card expected", out_card);
          mismatch_count++;
        end else begin
          want = cards_due.pop_front();
          compare_field("card", 32'(want.card), 32'(out_card));
          compare_field("column", 32'(want.column), 32'(out_column));
          compare_field("row", 32'(want.row), 32'(out_row));
          compare_field("last", 32'(want.last), 32'(out_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[lcg_card_deal_generator_core] ERROR");
      $finish;
    end
  end

  // Leaves start high after acceptance so a following deal keeps it up.
  task automatic send_deal(input logic [31:0] seed);
    start <= 1'b1;
    in_game_number <= seed;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (cards_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_seed();
    logic [31:0] s;
    case ($urandom_range(0, 4))
      0: s = $urandom_range(0, 32000);
      1: s = 32'h1 << $urandom_range(0, 31);
      2: s = ~(32'h1 << $urandom_range(0, 31));
      default: s = $urandom;
    endcase
    return s;
  endfunction

  task automatic test_seed_extremes();
    send_deal(32'h0000_0000);
    idle_for(3);
    send_deal(32'hffff_ffff);
    send_deal(32'h8000_0000);
    send_deal(32'h7fff_ffff);
    idle_for(1);
    send_deal(32'h0000_0001);
    send_deal(32'h0000_0002);
    idle_for(5);
  endtask

  task automatic test_known_deals();
    send_deal(32'd617);
    send_deal(32'd11982);
    idle_for(2);
    send_deal(32'd1000000);
    send_deal(32'd32000);
    idle_for(2);
  endtask

  // Four random deals sent back to back, start held high between them.
  task automatic test_back_to_back();
    repeat (4) send_deal($urandom);
    idle_for(1);
  endtask

  // The sender holds off until every queued card has come out.
  task automatic test_drain_pause();
    send_deal($urandom);
    wait_drained();
    send_deal(32'h5555_aaaa);
    wait_drained();
    idle_for(4);
  endtask

  task automatic test_random_bursts();
    int sent;
    int burst;
    sent = 0;
    while (sent < RANDOM_DEALS) begin
      burst = $urandom_range(1, 6);
      for (int i = 0; i < burst && sent < RANDOM_DEALS; i++) begin
        send_deal(random_seed());
        sent++;
      end
      // Mostly short gaps; some long, and some that wait for the queued cards to drain.
      case ($urandom_range(0, 5))
        0: ;
        1: idle_for($urandom_range(60, 420));
        2: if ($urandom_range(0, 3) == 0) wait_drained();
        default: idle_for($urandom_range(1, 12));
      endcase
    end
    idle_for(1);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_seed_extremes();
    test_known_deals();
    test_back_to_back();
    test_drain_pause();
    test_random_bursts();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && cards_due.size() == 0) begin
      $display("[lcg_card_deal_generator_core] OK");
    end else begin
      $display("[lcg_card_deal_generator_core] ERROR");
    end
    $finish;
  end

endmodule
